[rtl/fcdi_pkg.sv]
// Shared types, constants and stage map for the fan curve duty interpolator.
package fcdi_pkg;

    localparam int CURVE_POINTS = 10;
    localparam int HALF_POINTS  = CURVE_POINTS / 2;
    localparam int DUTY_W       = 7;
    localparam int TEMP_W       = 8;
    localparam int TEMP_IN_W    = TEMP_W + 1;
    localparam int IDX_W        = $clog2(CURVE_POINTS);
    localparam int DUTY_REG_W   = HALF_POINTS * DUTY_W;
    localparam int TEMP_REG_W   = HALF_POINTS * TEMP_W;
    localparam int CFG_W        = TEMP_REG_W;
    localparam int CFG_IDX_W    = 2;
    localparam int RPM_W        = 13;

    // interpolation arithmetic
    localparam int DELTA_W   = DUTY_W + 1;
    localparam int DIFF_W    = TEMP_W + 1;
    localparam int PROD_W    = DELTA_W + DIFF_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int QUO_W     = 15;
    localparam int DIV_STEP  = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;
    localparam int SUM_W     = QUO_W + 2;

    // pipeline stage map
    localparam int ST_SEG      = 0;
    localparam int ST_NUM      = 1;
    localparam int ST_DIV0     = 2;
    localparam int ST_DUTY     = ST_DIV0 + DIV_STAGES;
    localparam int ST_OUT      = ST_DUTY + 1;
    localparam int PIPE_STAGES = ST_OUT + 1;

    // reset curve: duties 20..100, temps 10..100
    localparam logic [DUTY_REG_W-1:0] DUTY_LO_RST = 35'd10800744980;
    localparam logic [DUTY_REG_W-1:0] DUTY_HI_RST = 35'd27012307890;
    localparam logic [TEMP_REG_W-1:0] TEMP_LO_RST = 40'd215421424650;
    localparam logic [TEMP_REG_W-1:0] TEMP_HI_RST = 40'd431011939900;

    localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd20;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
    localparam logic [DUTY_W-1:0] SAFE_MIN_A = 7'd60;
    localparam logic [DUTY_W-1:0] SAFE_MIN_B = 7'd80;
    localparam logic [DUTY_W-1:0] SAFE_MIN_C = 7'd85;
    localparam logic [DUTY_W-1:0] RPM_PER_PCT = 7'd75;
    localparam logic [RPM_W-1:0]  RPM_MAX    = 13'd7500;

    localparam logic [TEMP_W-1:0] SPAN_ONE = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_LO = 2'd0,
        REG_DUTY_HI = 2'd1,
        REG_TEMP_LO = 2'd2,
        REG_TEMP_HI = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_ORDER  = 2'd2,
        ST_SAFETY = 2'd3
    } t_status;

    // point i sits at [i] when {high, low} registers are concatenated
    typedef logic [CURVE_POINTS-1:0][DUTY_W-1:0] t_duty_vec;
    typedef logic [CURVE_POINTS-1:0][TEMP_W-1:0] t_temp_vec;

    // segment pick: out-of-segment cases carry zero delta/diff, span one
    typedef struct packed {
        logic [DUTY_W-1:0]        lo_duty;
        logic signed [DELTA_W-1:0] delta;
        logic signed [DIFF_W-1:0]  diff;
        logic [TEMP_W-1:0]         span;
    } t_seg;

    // divider word: remainder, dividend bits shifting out, quotient shifting in
    typedef struct packed {
        logic                neg;
        logic [DUTY_W-1:0]   lo_duty;
        logic [TEMP_W-1:0]   span;
        logic [TEMP_W-1:0]   rem;
        logic [QUO_W-1:0]    work;
    } t_div;

endpackage

[rtl/fcdi_segment.sv]
// Segment search: finds the bracketing curve points for one sample.
module fcdi_segment import fcdi_pkg::*; (
    input  logic signed [TEMP_IN_W-1:0] i_temperature_c,
    input  t_duty_vec                   i_duty,
    input  t_temp_vec                   i_temp,
    output t_seg                        o_seg
);

    logic signed [TEMP_IN_W:0] w_t;
    logic [CURVE_POINTS-1:0]   w_le;
    logic                      w_ge_last;
    logic [IDX_W-1:0]          w_idx;
    logic [IDX_W-1:0]          w_lo_idx;
    logic [TEMP_W-1:0]         w_hi_t;
    logic [TEMP_W-1:0]         w_lo_t;
    logic [DUTY_W-1:0]         w_hi_d;
    logic [DUTY_W-1:0]         w_lo_d;
    logic signed [TEMP_IN_W:0] w_diff;

    assign w_t = {i_temperature_c[TEMP_IN_W-1], i_temperature_c};

    always_comb begin
        for (int i = 0; i < CURVE_POINTS; i++) begin
            w_le[i] = w_t <= $signed({2'b00, i_temp[i]});
        end
        w_ge_last = w_t >= $signed({2'b00, i_temp[CURVE_POINTS-1]});
    end

    // first point at or above the sample, from point 1 up
    always_comb begin
        w_idx = IDX_W'(CURVE_POINTS - 1);
        for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
            if (w_le[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    assign w_lo_idx = w_idx - 1'b1;
    assign w_hi_t   = i_temp[w_idx];
    assign w_lo_t   = i_temp[w_lo_idx];
    assign w_hi_d   = i_duty[w_idx];
    assign w_lo_d   = i_duty[w_lo_idx];
    assign w_diff   = w_t - $signed({2'b00, w_lo_t});

    always_comb begin
        o_seg.lo_duty = w_lo_d;
        o_seg.delta   = $signed({1'b0, w_hi_d} - {1'b0, w_lo_d});
        o_seg.diff    = w_diff[DIFF_W-1:0];
        o_seg.span    = w_hi_t - w_lo_t;
        if (w_le[0] || w_ge_last || (w_hi_t <= w_lo_t)) begin
            o_seg.delta = '0;
            o_seg.diff  = '0;
            o_seg.span  = SPAN_ONE;
            if (w_le[0]) begin
                o_seg.lo_duty = i_duty[0];
            end else if (w_ge_last) begin
                o_seg.lo_duty = i_duty[CURVE_POINTS-1];
            end
        end
    end

endmodule

[rtl/fcdi_div_stage.sv]
// One divider stage: DIV_STEP restoring quotient bits.
module fcdi_div_stage import fcdi_pkg::*; (
    input  t_div i_div,
    output t_div o_div
);

    logic [TEMP_W:0] w_trial;

    always_comb begin
        o_div   = i_div;
        w_trial = '0;
        for (int s = 0; s < DIV_STEP; s++) begin
            w_trial = {o_div.rem, o_div.work[QUO_W-1]};
            if (w_trial >= {1'b0, o_div.span}) begin
                w_trial  = w_trial - {1'b0, o_div.span};
                o_div.work = {o_div.work[QUO_W-2:0], 1'b1};
            end else begin
                o_div.work = {o_div.work[QUO_W-2:0], 1'b0};
            end
            o_div.rem = w_trial[TEMP_W-1:0];
        end
    end

endmodule

[rtl/fcdi_curve_check.sv]
// Curve check: duty range, monotonic order and safety minimums.
module fcdi_curve_check import fcdi_pkg::*; (
    input  t_duty_vec i_duty,
    output t_status   o_status
);

    always_comb begin
        if (i_duty[CURVE_POINTS-3] < SAFE_MIN_A || i_duty[CURVE_POINTS-2] < SAFE_MIN_B ||
            i_duty[CURVE_POINTS-1] < SAFE_MIN_C) begin
            o_status = ST_SAFETY;
        end else begin
            o_status = ST_OK;
        end
        // walk down so the lowest failing point wins; range beats order
        for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
            if (i_duty[i] < DUTY_MIN || i_duty[i] > DUTY_MAX) begin
                o_status = ST_RANGE;
            end else if (i != 0 && i_duty[i] < i_duty[(i == 0) ? 0 : i - 1]) begin
                o_status = ST_ORDER;
            end
        end
    end

endmodule

[rtl/fan_curve_duty_interpolator_core.sv]
// Top level: fan curve duty interpolator pipeline with config registers.
//
// Usage:
//   Input channel: i_valid / o_stall carry one temperature word
//   (i_temperature_c, signed degrees C). Output channel: o_valid / i_stall
//   carry one result word per sample: duty percent, RPM estimate and the
//   curve check code. A word moves when valid is high and stall is low.
//   Config: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 duty low, 1 duty high, 2 temp low, 3 temp high); write only while
//   no sample is in flight.
//   Path from input accept to o_valid: segment search, multiply,
//   five 3-bit divider stages, sum, clamp/scale. Throughput: one word per
//   cycle while i_stall is low, set by the fully pipelined divider.
//   Each stage holds a valid bit and advances when the stage after it is
//   empty or moving, so a stalled output only backs up until bubbles fill;
//   o_stall rises once every stage is full. Nothing is dropped or repeated.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default curve: duties 20,20,25,30,40,50,55,60,80,100 at 10..100 C.
module fan_curve_duty_interpolator_core import fcdi_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [TEMP_IN_W-1:0] i_temperature_c,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [DUTY_W-1:0]           o_duty_percent,
    output logic [RPM_W-1:0]            o_rpm_estimate,
    output logic [1:0]                  o_curve_status,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_wdata
);

    // ---------------- config registers ----------------
    logic [DUTY_REG_W-1:0] r_duty_lo, r_duty_hi;
    logic [TEMP_REG_W-1:0] r_temp_lo, r_temp_hi;
    t_duty_vec             w_duty;
    t_temp_vec             w_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_lo <= DUTY_LO_RST;
            r_duty_hi <= DUTY_HI_RST;
            r_temp_lo <= TEMP_LO_RST;
            r_temp_hi <= TEMP_HI_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DUTY_LO: r_duty_lo <= i_cfg_wdata[DUTY_REG_W-1:0];
                REG_DUTY_HI: r_duty_hi <= i_cfg_wdata[DUTY_REG_W-1:0];
                REG_TEMP_LO: r_temp_lo <= i_cfg_wdata[TEMP_REG_W-1:0];
                REG_TEMP_HI: r_temp_hi <= i_cfg_wdata[TEMP_REG_W-1:0];
            endcase
        end
    end

    // point i lands at [i] of the concatenation
    assign w_duty = {r_duty_hi, r_duty_lo};
    assign w_temp = {r_temp_hi, r_temp_lo};

    // ---------------- pipeline control ----------------
    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_adv;

    // a stage may load when it is empty or its word moves on
    always_comb begin
        w_adv[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || !i_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (w_adv[k]) begin
                n_valid[k] = (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !w_adv[ST_SEG];
    assign o_valid = r_valid[ST_OUT];

    // ---------------- stage 0: segment search ----------------
    t_seg w_seg;
    t_seg r_seg;

    fcdi_segment u_segment (
        .i_temperature_c (i_temperature_c),
        .i_duty          (w_duty),
        .i_temp          (w_temp),
        .o_seg           (w_seg)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SEG]) begin
            r_seg <= w_seg;
        end
    end

    // ---------------- stage 1: numerator = delta*diff + span/2 ----------------
    logic signed [PROD_W-1:0] w_prod;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [NUM_W-1:0]  w_mag;
    t_div                     n_div_in;
    t_div                     r_div_in;

    assign w_prod = r_seg.delta * r_seg.diff;
    assign w_num  = $signed({w_prod[PROD_W-1], w_prod}) +
                    $signed({{(NUM_W-TEMP_W+1){1'b0}}, r_seg.span[TEMP_W-1:1]});
    assign w_mag  = w_num[NUM_W-1] ? -w_num : w_num;

    always_comb begin
        n_div_in.neg     = w_num[NUM_W-1];
        n_div_in.lo_duty = r_seg.lo_duty;
        n_div_in.span    = r_seg.span;
        n_div_in.rem     = '0;
        n_div_in.work    = w_mag[QUO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_NUM]) begin
            r_div_in <= n_div_in;
        end
    end

    // ---------------- stages 2..6: pipelined restoring divider ----------------
    t_div r_div [DIV_STAGES];
    t_div w_div [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        fcdi_div_stage u_div_stage (
            .i_div (j == 0 ? r_div_in : r_div[(j == 0) ? 0 : j - 1]),
            .o_div (w_div[j])
        );

        always_ff @(posedge i_clk) begin
            if (w_adv[ST_DIV0 + j]) begin
                r_div[j] <= w_div[j];
            end
        end
    end

    // ---------------- stage 7: signed quotient plus lower duty ----------------
    t_div                    w_div_last;
    logic signed [SUM_W-1:0] w_quo;
    logic signed [SUM_W-1:0] r_duty_sum;

    assign w_div_last = r_div[DIV_STAGES-1];
    // truncation toward zero: divide magnitudes, then restore the sign
    assign w_quo = w_div_last.neg ? -$signed({2'b00, w_div_last.work})
                                  :  $signed({2'b00, w_div_last.work});

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_DUTY]) begin
            r_duty_sum <= w_quo + $signed({{(SUM_W-DUTY_W){1'b0}}, w_div_last.lo_duty});
        end
    end

    // ---------------- stage 8: clamp for RPM scale, output word (duty unclamped) ----------------
    logic [DUTY_W-1:0] w_clamped;
    logic [RPM_W-1:0]  w_rpm;
    t_status           w_status;
    logic [DUTY_W-1:0] r_out_duty;
    logic [RPM_W-1:0]  r_out_rpm;
    t_status           r_out_status;

    fcdi_curve_check u_curve_check (
        .i_duty   (w_duty),
        .o_status (w_status)
    );

    always_comb begin
        if (r_duty_sum[SUM_W-1]) begin
            w_clamped = '0;
        end else if (r_duty_sum > $signed({{(SUM_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
            w_clamped = DUTY_MAX;
        end else begin
            w_clamped = r_duty_sum[DUTY_W-1:0];
        end
    end

    // widen both factors first: 100 * 75 needs all 13 bits
    assign w_rpm = RPM_W'(w_clamped) * RPM_W'(RPM_PER_PCT);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_out_duty   <= r_duty_sum[DUTY_W-1:0];
            r_out_rpm    <= w_rpm;
            r_out_status <= w_status;
        end
    end

    assign o_duty_percent = r_out_duty;
    assign o_rpm_estimate = r_out_rpm;
    assign o_curve_status = r_out_status;

`ifndef NO_ASSERTIONS
    // an unstalled output lets the whole pipeline move
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output not stalled");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_DUTY-1] |-> (w_div_last.rem < w_div_last.span))
        else $error("divider remainder not below span");

    // RPM estimate never exceeds the clamped maximum
    a_rpm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rpm_estimate <= RPM_MAX))
        else $error("rpm estimate out of range");
`endif

endmodule
